// ===== rtl/core/capscan_pkg.sv =====
// Shared types and constants for the constructed-address pair scanner.
package capscan_pkg;

    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int REG_W   = 5;
    localparam int OPC_W   = 6;
    localparam int DIST_W  = 4;

    // Primary opcodes of interest
    localparam logic [OPC_W-1:0] OP_ADD_IMM = 6'd14;
    localparam logic [OPC_W-1:0] OP_UPPER   = 6'd15;
    localparam logic [OPC_W-1:0] OP_OR_IMM  = 6'd24;

    // Result kind codes
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_OR  = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] instruction_word;
        logic              section_end;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] built_address;
        logic              pair_kind;
        logic [DIST_W-1:0] pair_distance;
        logic              run_last;
    } out_word_t;

    // One window entry: a pending upper-half load
    typedef struct packed {
        logic              valid;
        logic [REG_W-1:0]  rgst;
        logic [HALF_W-1:0] upper;
    } entry_t;

    // Decoded fields of the incoming word, broadcast to all cells
    typedef struct packed {
        logic             is_add;
        logic             is_or;
        logic [REG_W-1:0] src_add;
        logic [REG_W-1:0] src_or;
    } probe_t;

endpackage

// ===== rtl/core/capscan_cell.sv =====
// One window cell: holds an upper-half load entry and its pending match slot.
module capscan_cell
    import capscan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              flush,
    input  entry_t            entry_prev,
    output entry_t            entry,
    input  probe_t            probe,
    input  logic              take,
    input  logic              above_in,
    output logic              above_out,
    output logic              hit,
    output logic              sel,
    output logic [HALF_W-1:0] upper
);

    logic              valid_reg;
    logic              valid_next;
    logic [REG_W-1:0]  rgst_reg;
    logic [HALF_W-1:0] upper_reg;
    logic              slot_hit_reg;
    logic              slot_hit_next;
    logic [HALF_W-1:0] slot_upper_reg;
    logic              match;

    // Compare the incoming word against this entry
    assign match = valid_reg &
                   ((probe.is_add & (probe.src_add == rgst_reg)) |
                    (probe.is_or  & (probe.src_or  == rgst_reg)));

    // Oldest pending match wins the drain
    assign sel       = slot_hit_reg & ~above_in;
    assign above_out = above_in | slot_hit_reg;
    assign hit       = slot_hit_reg;
    assign upper     = sel ? slot_upper_reg : '0;

    assign entry.valid = valid_reg;
    assign entry.rgst  = rgst_reg;
    assign entry.upper = upper_reg;

    // Next-state logic
    always_comb
    begin
        valid_next    = valid_reg;
        slot_hit_next = slot_hit_reg;
        if (shift)
        begin
            valid_next    = entry_prev.valid & ~flush;
            slot_hit_next = match;
        end
        else if (take && sel)
        begin
            slot_hit_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            slot_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            slot_hit_reg <= slot_hit_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rgst_reg       <= entry_prev.rgst;
            upper_reg      <= entry_prev.upper;
            slot_upper_reg <= upper_reg;
        end
    end

endmodule

// ===== rtl/core/capscan_drain.sv =====
// Result builder: forms the address of the selected match and holds the output register.
module capscan_drain
    import capscan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [HALF_W-1:0] low,
    input  logic              kind,
    input  logic              busy,
    input  logic              last,
    input  logic [HALF_W-1:0] sel_upper,
    input  logic [DIST_W-1:0] sel_dist,
    input  logic              result_stall,
    output logic              issue,
    output logic              result_valid,
    output out_word_t         result
);

    logic [HALF_W-1:0] pend_low_reg;
    logic              pend_kind_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    out_word_t         result_reg;
    out_word_t         result_next;
    logic [WORD_W-1:0] addr;

    // Issue a match whenever the output register is free or being emptied
    assign issue = busy & (~result_valid_reg | ~result_stall);

    // Address formation
    always_comb
    begin
        if (pend_kind_reg == KIND_ADD)
        begin
            addr = {sel_upper, {HALF_W{1'b0}}} +
                   {{(WORD_W-HALF_W){pend_low_reg[HALF_W-1]}}, pend_low_reg};
        end
        else
        begin
            addr = {sel_upper, pend_low_reg};
        end
    end

    always_comb
    begin
        result_next.built_address = addr;
        result_next.pair_kind     = pend_kind_reg;
        result_next.pair_distance = sel_dist;
        result_next.run_last      = last;
        if (issue)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Per-word immediate and kind, plus the output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_low_reg  <= low;
            pend_kind_reg <= kind;
        end
        if (issue)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/constructed_address_pair_scanner_top.sv =====
// Top level of the constructed-address pair scanner: cell chain plus result drain.
// A word's matches are held in the cells' match slots, then registered at the output.
// Throughput: one word per cycle when no match is pending, else the input stalls until
// the single output register, one match per cycle unless stalled, issues the last match.
// Reset: rst_n clears the window valid bits, pending matches and the output valid.
module constructed_address_pair_scanner_top
    import capscan_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      word_valid,
    output logic      word_stall,
    input  in_word_t  word,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    logic                    accept;
    logic                    issue;
    logic                    busy;
    logic                    last;
    probe_t                  probe;
    entry_t                  fresh;
    entry_t                  entry_link [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] above_link;
    logic [WINDOW_DEPTH-1:0] hit_vec;
    logic [WINDOW_DEPTH-1:0] sel_vec;
    logic [HALF_W-1:0]       upper_vec [WINDOW_DEPTH];
    logic [HALF_W-1:0]       sel_upper;
    logic [DIST_W-1:0]       sel_dist;
    logic [OPC_W-1:0]        opcode;

    // Decode the incoming word
    assign opcode        = word.instruction_word[WORD_W-1 -: OPC_W];
    assign probe.is_add  = (opcode == OP_ADD_IMM);
    assign probe.is_or   = (opcode == OP_OR_IMM);
    assign probe.src_add = word.instruction_word[20:16];
    assign probe.src_or  = word.instruction_word[25:21];

    assign fresh.valid = (opcode == OP_UPPER) && (word.instruction_word[20:16] == '0);
    assign fresh.rgst  = word.instruction_word[25:21];
    assign fresh.upper = word.instruction_word[HALF_W-1:0];

    // Input handshake: take a new word unless matches remain beyond this cycle
    assign busy       = |hit_vec;
    assign last       = ~|(hit_vec & ~sel_vec);
    assign word_stall = busy & ~(issue & last);
    assign accept     = word_valid & ~word_stall;

    // Window cells, newest at index 0
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   above_in;

        if (i == 0)
        begin : g_head
            assign prev_entry = fresh;
        end
        else
        begin : g_body
            assign prev_entry = entry_link[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_oldest
            assign above_in = 1'b0;
        end
        else
        begin : g_younger
            assign above_in = above_link[i+1];
        end

        capscan_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .flush      (word.section_end),
            .entry_prev (prev_entry),
            .entry      (entry_link[i]),
            .probe      (probe),
            .take       (issue),
            .above_in   (above_in),
            .above_out  (above_link[i]),
            .hit        (hit_vec[i]),
            .sel        (sel_vec[i]),
            .upper      (upper_vec[i])
        );
    end

    // One-hot merge of the selected cell's upper half and distance
    always_comb
    begin
        sel_upper = '0;
        sel_dist  = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            sel_upper = sel_upper | upper_vec[i];
            if (sel_vec[i])
            begin
                sel_dist = sel_dist | DIST_W'(i + 1);
            end
        end
    end

    capscan_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .low          (word.instruction_word[HALF_W-1:0]),
        .kind         (probe.is_or ? KIND_OR : KIND_ADD),
        .busy         (busy),
        .last         (last),
        .sel_upper    (sel_upper),
        .sel_dist     (sel_dist),
        .result_stall (result_stall),
        .issue        (issue),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== bench/capscan_scoreboard_pkg.sv =====
// Scoreboard for the pair scanner: window predictor plus ordered match checker.
package capscan_scoreboard_pkg;

    import capscan_pkg::*;

    localparam int SB_WINDOW = 8;

    class pair_scoreboard;

        entry_t    window[SB_WINDOW];
        out_word_t expected_matches[$];
        int        errors;
        int        words_seen;
        int        matches_seen;
        int        sections_closed;
        int        longest_burst;

        function new();
            errors          = 0;
            words_seen      = 0;
            matches_seen    = 0;
            sections_closed = 0;
            longest_burst   = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int i = 0; i < SB_WINDOW; i++)
            begin
                window[i] = '0;
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        // Predict the matches of one accepted word, then shift it into the window
        function void note_word(in_word_t w);
            logic [OPC_W-1:0]  opc;
            logic [REG_W-1:0]  src_add;
            logic [REG_W-1:0]  src_or;
            logic [HALF_W-1:0] low;
            logic [WORD_W-1:0] upper_word;
            logic [WORD_W-1:0] addr;
            logic              kind;
            logic              hit;
            out_word_t         match;
            out_word_t         burst[$];

            opc     = w.instruction_word[31:26];
            src_or  = w.instruction_word[25:21];
            src_add = w.instruction_word[20:16];
            low     = w.instruction_word[15:0];
            words_seen++;

            // oldest cell first
            for (int i = SB_WINDOW - 1; i >= 0; i--)
            begin
                if (window[i].valid)
                begin
                    upper_word = {window[i].upper, {HALF_W{1'b0}}};
                    hit        = 1'b1;
                    addr       = '0;
                    kind       = KIND_ADD;
                    if (opc == OP_ADD_IMM && src_add == window[i].rgst)
                    begin
                        addr = upper_word + {{HALF_W{low[HALF_W-1]}}, low};
                        kind = KIND_ADD;
                    end
                    else if (opc == OP_OR_IMM && src_or == window[i].rgst)
                    begin
                        addr = upper_word | {{HALF_W{1'b0}}, low};
                        kind = KIND_OR;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end
                    if (hit)
                    begin
                        match.built_address = addr;
                        match.pair_kind     = kind;
                        match.pair_distance = DIST_W'(i + 1);
                        match.run_last      = 1'b0;
                        burst.push_back(match);
                    end
                end
            end

            if (burst.size() > 0)
            begin
                burst[burst.size() - 1].run_last = 1'b1;
                if (burst.size() > longest_burst)
                    longest_burst = burst.size();
            end
            foreach (burst[k])
            begin
                expected_matches.push_back(burst[k]);
            end

            // shift window; only lis with base zero is a live entry
            for (int i = SB_WINDOW - 1; i > 0; i--)
            begin
                window[i] = window[i - 1];
            end
            window[0].valid = (opc == OP_UPPER) && (src_add == '0);
            window[0].rgst  = src_or;
            window[0].upper = low;

            if (w.section_end)
            begin
                sections_closed++;
                clear_window();
            end
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(out_word_t got);
            out_word_t want;

            matches_seen++;
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result word: address %h kind %0d distance %0d last %0d",
                       got.built_address, got.pair_kind, got.pair_distance, got.run_last);
                errors++;
                return;
            end
            want = expected_matches.pop_front();
            if (got.built_address !== want.built_address)
            begin
                $error("built_address: expected %h, actual %h",
                       want.built_address, got.built_address);
                errors++;
            end
            if (got.pair_kind !== want.pair_kind)
            begin
                $error("pair_kind: expected %0d, actual %0d", want.pair_kind, got.pair_kind);
                errors++;
            end
            if (got.pair_distance !== want.pair_distance)
            begin
                $error("pair_distance: expected %0d, actual %0d",
                       want.pair_distance, got.pair_distance);
                errors++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for the pair scanner: clock, reset, word drivers and result monitor.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import capscan_pkg::*;
    import capscan_scoreboard_pkg::*;

    localparam int  SETTLE_CYCLES  = 6;
    localparam int  RANDOM_PER_MIX = 130;
    localparam time RUN_LIMIT      = 5_000_000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      word_valid   = 1'b0;
    logic      word_stall;
    in_word_t  word         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    pair_scoreboard sb;

    constructed_address_pair_scanner_top #(
        .WINDOW_DEPTH(SB_WINDOW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word         (word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // handshake monitor: results first, then the newly accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (word_valid && !word_stall)
                sb.note_word(word);
        end
    end

    function automatic logic [WORD_W-1:0] encode(logic [OPC_W-1:0] opc,
                                                 logic [REG_W-1:0] hi_field,
                                                 logic [REG_W-1:0] lo_field,
                                                 logic [HALF_W-1:0] imm);
        return {opc, hi_field, lo_field, imm};
    endfunction

    function automatic in_word_t pack_word(logic [WORD_W-1:0] bits, logic last);
        return {bits, last};
    endfunction

    // mostly a few hot registers so pairs actually meet
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(3) == 0)
            return REG_W'($urandom_range(31));
        return REG_W'($urandom_range(3));
    endfunction

    function automatic in_word_t random_word();
        int                pick;
        logic [REG_W-1:0]  reg_a;
        logic [REG_W-1:0]  reg_b;
        logic [HALF_W-1:0] imm;
        logic [WORD_W-1:0] bits;

        pick  = $urandom_range(99);
        reg_a = pick_reg();
        reg_b = REG_W'($urandom_range(31));
        imm   = HALF_W'($urandom);
        if (pick < 30)
            bits = encode(OP_UPPER, reg_a, '0, imm);
        else if (pick < 38)
            bits = encode(OP_UPPER, reg_a, REG_W'($urandom_range(31, 1)), imm);
        else if (pick < 60)
            bits = encode(OP_ADD_IMM, reg_b, reg_a, imm);
        else if (pick < 82)
            bits = encode(OP_OR_IMM, reg_a, reg_b, imm);
        else
            bits = $urandom;
        return pack_word(bits, $urandom_range(15) == 0);
    endfunction

    // offer one word, idling first at the current rate, hold until taken
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        word       <= w;
        @(posedge clk);
        while (word_stall)
            @(posedge clk);
    endtask

    // stop sending until every predicted match has been taken
    task automatic drain_matches();
        word_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        // lis r0 with all-ones upper, addi off r0 with most negative low half
        send_word(pack_word(encode(OP_UPPER, 5'd0, 5'd0, 16'hFFFF), 1'b0));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd9, 5'd0, 16'h8000), 1'b0));
        // top register, or and add forms with extreme low halves
        send_word(pack_word(encode(OP_UPPER, 5'd31, 5'd0, 16'h8000), 1'b0));
        send_word(pack_word(encode(OP_OR_IMM, 5'd31, 5'd31, 16'hFFFF), 1'b0));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd0, 5'd31, 16'h7FFF), 1'b0));
        // upper load with nonzero base never pairs
        send_word(pack_word(encode(OP_UPPER, 5'd4, 5'd1, 16'h1234), 1'b0));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd4, 5'd4, 16'h0001), 1'b0));
        // plain words, the second one closes the section
        send_word(pack_word(32'h0000_0000, 1'b0));
        send_word(pack_word(32'hFFFF_FFFF, 1'b1));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd1, 5'd0, 16'h0000), 1'b0));
        // match on the closing word itself, none after it
        send_word(pack_word(encode(OP_UPPER, 5'd3, 5'd0, 16'h1000), 1'b0));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd3, 5'd3, 16'h0000), 1'b1));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd3, 5'd3, 16'h0010), 1'b0));
        // full window of the same register: widest burst, distances 8 down to 1
        for (int k = 0; k < SB_WINDOW; k++)
        begin
            send_word(pack_word(encode(OP_UPPER, 5'd5, 5'd0, HALF_W'(16'h0F00 + k)), 1'b0));
        end
        send_word(pack_word(encode(OP_OR_IMM, 5'd5, 5'd6, 16'hAAAA), 1'b0));
        send_word(pack_word(encode(OP_ADD_IMM, 5'd6, 5'd5, 16'hC001), 1'b0));
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            send_word(random_word());
        end
        drain_matches();
    endtask

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idles, receiver stalls often
        send_idle_pct  = 9;
        recv_stall_pct = 56;
        run_directed();
        drain_matches();
        run_random(RANDOM_PER_MIX);

        // sender idles often, receiver rarely stalls
        send_idle_pct  = 56;
        recv_stall_pct = 9;
        run_random(RANDOM_PER_MIX);

        // back to back, no stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_MIX);

        $display("Scanned %0d words over three stall mixes, %0d section ends.",
                 sb.words_seen, sb.sections_closed);
        $display("Checked %0d address pairs; widest burst %0d matches, %0d mismatches.",
                 sb.matches_seen, sb.longest_burst, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
